FILE: rtl/cosine_similarity_score_assert.svh
// Assertion macros for the cosine similarity scorer.
// Expects clk and rst_n in the scope where the macros are used.
`ifndef COSINE_SIMILARITY_SCORE_ASSERT_SVH
`define COSINE_SIMILARITY_SCORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define CSS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/cssc_pkg.sv
// Shared types and constants for the cosine similarity scorer.
// No dependencies; used by every module in rtl/.
package cssc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int SEXT_SH     = (SAMPLE_BITS >= 17) ? 0 : 17 - SAMPLE_BITS;

    localparam int DOT_W  = 42;
    localparam int EN_W   = 41;
    localparam int SMP_W  = 17;
    localparam int PROD_W = 2 * SMP_W;

    localparam logic [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
    localparam logic [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};
    localparam logic [EN_W-1:0]  EN_MAX  = {EN_W{1'b1}};

    typedef struct packed {
        logic busy;
        logic done;
    } cssc_unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_DQ,
        ST_MUL_DD,
        ST_MUL_QQ,
        ST_ACC_QQ,
        ST_CHECK,
        ST_ROOT_D,
        ST_ROOT_Q,
        ST_DEN,
        ST_SHIFT,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FIN
    } cssc_state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_NORM,
        R_ITER
    } cssc_root_state_t;

    typedef enum logic {
        D_IDLE,
        D_RUN
    } cssc_div_state_t;

    // Sign-extend the low SAMPLE_BITS of a raw field to 17 bits.
    function automatic logic signed [SMP_W-1:0] sext_sample(input logic [15:0] raw);
        logic signed [SMP_W-1:0] t;
        t = $signed({1'b0, raw} << SEXT_SH);
        return t >>> SEXT_SH;
    endfunction

endpackage

FILE: rtl/cosine_similarity_score.sv
// Top level of the cosine similarity scorer: sequencer, accumulators, output beat.
// Depends on cssc_pkg, cssc_mul, cssc_root, cssc_div, cosine_similarity_score_assert.svh.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------------
//  in      | sink      | in_valid / in_stall  | data_element query_element last_element
//          |           |                      | last_vector
//  out     | source    | out_valid/ out_stall | score zero_norm last_score
//
// An element beat is accepted, then runs four steps of the shared multiplier
// and accumulator adder. A beat marked last_element then runs, unless either
// energy is zero, two passes of the shared root unit (0 to 15 normalize
// shifts, one setup step, 16 root steps and a done pulse each), one multiply,
// a numerator shift and the 17-step divider, plus any wait for the output register.
// Reset clears the sequencer and all three accumulators.
// A finished score waits in the output register; the next vector is accepted while
// it waits, and only a following score stalls behind an unread one.
module cosine_similarity_score (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] data_element,
    input  logic signed [15:0] query_element,
    input  logic               last_element,
    input  logic               last_vector,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] score,
    output logic               zero_norm,
    output logic               last_score
);

    localparam int DW = cssc_pkg::DOT_W;
    localparam int EW = cssc_pkg::EN_W;
    localparam int SW = cssc_pkg::SMP_W;
    localparam int PW = cssc_pkg::PROD_W;

    cssc_pkg::cssc_state_t state_reg, state_next;

    logic [DW-1:0]          dot_reg, dot_next;
    logic [EW-1:0]          den_e_reg, den_e_next;   // data energy
    logic [EW-1:0]          qry_e_reg, qry_e_next;   // query energy
    logic                   out_valid_reg, out_valid_next;

    logic signed [SW-1:0]   d_reg, d_next;
    logic signed [SW-1:0]   q_reg, q_next;
    logic                   last_el_reg, last_el_next;
    logic                   last_vec_reg, last_vec_next;
    logic                   zero_reg, zero_next;
    logic [15:0]            rd_reg, rd_next;
    logic [15:0]            rq_reg, rq_next;
    logic signed [5:0]      kd_reg, kd_next;
    logic signed [5:0]      kq_reg, kq_next;
    logic [62:0]            num_reg, num_next;
    logic [31:0]            divisor_reg, divisor_next;
    logic                   ovf_reg, ovf_next;
    logic signed [15:0]     score_reg, score_next;
    logic                   zero_norm_reg, zero_norm_next;
    logic                   last_score_reg, last_score_next;

    logic signed [SW-1:0]   mul_a, mul_b;
    logic signed [PW-1:0]   prod;

    logic                   root_start;
    logic [EW-1:0]          root_energy;
    logic [15:0]            root;
    logic signed [5:0]      root_k;
    cssc_pkg::cssc_unit_stat_t root_stat;

    logic                   div_start;
    logic [16:0]            quo;
    logic                   div_sat;
    cssc_pkg::cssc_unit_stat_t div_stat;

    logic signed [DW:0]     add_a, add_b, add_sum;
    logic                   fin_go;
    logic                   neg;
    logic [DW-1:0]          mag;
    logic signed [6:0]      sh_raw;
    logic [5:0]             sh;
    logic [86:0]            mag_sh;
    logic                   sat_any;
    logic [16:0]            neg_q;

    cssc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    cssc_root u_root (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (root_start),
        .energy (root_energy),
        .root   (root),
        .k      (root_k),
        .stat   (root_stat)
    );

    cssc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (divisor_reg),
        .quo   (quo),
        .sat   (div_sat),
        .stat  (div_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cssc_pkg::ST_IDLE;
            dot_reg       <= '0;
            den_e_reg     <= '0;
            qry_e_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dot_reg       <= dot_next;
            den_e_reg     <= den_e_next;
            qry_e_reg     <= qry_e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg          <= d_next;
        q_reg          <= q_next;
        last_el_reg    <= last_el_next;
        last_vec_reg   <= last_vec_next;
        zero_reg       <= zero_next;
        rd_reg         <= rd_next;
        rq_reg         <= rq_next;
        kd_reg         <= kd_next;
        kq_reg         <= kq_next;
        num_reg        <= num_next;
        divisor_reg    <= divisor_next;
        ovf_reg        <= ovf_next;
        score_reg      <= score_next;
        zero_norm_reg  <= zero_norm_next;
        last_score_reg <= last_score_next;
    end

    // score arithmetic helpers
    always_comb
    begin
        neg     = dot_reg[DW-1];
        mag     = neg ? (~dot_reg + {{(DW-1){1'b0}}, 1'b1}) : dot_reg;
        sh_raw  = 7'sd15 + {kd_reg[5], kd_reg} + {kq_reg[5], kq_reg};
        sh      = sh_raw[6] ? 6'd0 : sh_raw[5:0];
        mag_sh  = {45'd0, mag} << sh;
        sat_any = ovf_reg | div_sat;
        neg_q   = ~quo + 17'd1;
    end

    assign fin_go = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        dot_next        = dot_reg;
        den_e_next      = den_e_reg;
        qry_e_next      = qry_e_reg;
        out_valid_next  = out_valid_reg && out_stall;
        d_next          = d_reg;
        q_next          = q_reg;
        last_el_next    = last_el_reg;
        last_vec_next   = last_vec_reg;
        zero_next       = zero_reg;
        rd_next         = rd_reg;
        rq_next         = rq_reg;
        kd_next         = kd_reg;
        kq_next         = kq_reg;
        num_next        = num_reg;
        divisor_next    = divisor_reg;
        ovf_next        = ovf_reg;
        score_next      = score_reg;
        zero_norm_next  = zero_norm_reg;
        last_score_next = last_score_reg;
        mul_a           = d_reg;
        mul_b           = q_reg;
        root_start      = 1'b0;
        root_energy     = den_e_reg;
        div_start       = 1'b0;
        add_a           = {dot_reg[DW-1], dot_reg};
        add_b           = {{(DW+1-PW){prod[PW-1]}}, prod};
        add_sum         = add_a + add_b;

        unique case (state_reg)
            cssc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    d_next        = cssc_pkg::sext_sample(data_element);
                    q_next        = cssc_pkg::sext_sample(query_element);
                    last_el_next  = last_element;
                    last_vec_next = last_vector;
                    state_next    = cssc_pkg::ST_MUL_DQ;
                end
            end
            cssc_pkg::ST_MUL_DQ:
            begin
                state_next = cssc_pkg::ST_MUL_DD;
            end
            cssc_pkg::ST_MUL_DD:
            begin
                // product register holds d*q
                mul_b = d_reg;
                if (add_sum[DW] != add_sum[DW-1])
                begin
                    dot_next = add_sum[DW] ? cssc_pkg::DOT_MIN : cssc_pkg::DOT_MAX;
                end
                else
                begin
                    dot_next = add_sum[DW-1:0];
                end
                state_next = cssc_pkg::ST_MUL_QQ;
            end
            cssc_pkg::ST_MUL_QQ:
            begin
                // product register holds d*d
                mul_a   = q_reg;
                add_a   = {2'b00, den_e_reg};
                add_sum = add_a + add_b;
                den_e_next = (add_sum[DW:EW] != '0) ? cssc_pkg::EN_MAX : add_sum[EW-1:0];
                state_next = cssc_pkg::ST_ACC_QQ;
            end
            cssc_pkg::ST_ACC_QQ:
            begin
                // product register holds q*q
                add_a   = {2'b00, qry_e_reg};
                add_sum = add_a + add_b;
                qry_e_next = (add_sum[DW:EW] != '0) ? cssc_pkg::EN_MAX : add_sum[EW-1:0];
                state_next = last_el_reg ? cssc_pkg::ST_CHECK : cssc_pkg::ST_IDLE;
            end
            cssc_pkg::ST_CHECK:
            begin
                zero_next = (den_e_reg == '0) || (qry_e_reg == '0);
                if ((den_e_reg == '0) || (qry_e_reg == '0))
                begin
                    state_next = cssc_pkg::ST_FIN;
                end
                else
                begin
                    root_start = 1'b1;
                    state_next = cssc_pkg::ST_ROOT_D;
                end
            end
            cssc_pkg::ST_ROOT_D:
            begin
                root_energy = qry_e_reg;
                if (root_stat.done)
                begin
                    rd_next    = root;
                    kd_next    = root_k;
                    root_start = 1'b1;
                    state_next = cssc_pkg::ST_ROOT_Q;
                end
            end
            cssc_pkg::ST_ROOT_Q:
            begin
                root_energy = qry_e_reg;
                if (root_stat.done)
                begin
                    rq_next    = root;
                    kq_next    = root_k;
                    state_next = cssc_pkg::ST_DEN;
                end
            end
            cssc_pkg::ST_DEN:
            begin
                mul_a      = $signed({1'b0, rd_reg});
                mul_b      = $signed({1'b0, rq_reg});
                state_next = cssc_pkg::ST_SHIFT;
            end
            cssc_pkg::ST_SHIFT:
            begin
                divisor_next = prod[31:0];
                num_next     = mag_sh[62:0];
                ovf_next     = |mag_sh[86:63];
                state_next   = cssc_pkg::ST_DIV_START;
            end
            cssc_pkg::ST_DIV_START:
            begin
                div_start  = 1'b1;
                state_next = cssc_pkg::ST_DIV_WAIT;
            end
            cssc_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = cssc_pkg::ST_FIN;
                end
            end
            cssc_pkg::ST_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next  = 1'b1;
                    zero_norm_next  = zero_reg;
                    last_score_next = last_vec_reg;
                    if (zero_reg)
                    begin
                        score_next = 16'sd0;
                    end
                    else if (neg)
                    begin
                        score_next = (sat_any || quo > 17'd32768) ? 16'sh8000
                                                                  : $signed(neg_q[15:0]);
                    end
                    else
                    begin
                        score_next = (sat_any || quo > 17'd32767) ? 16'sh7fff
                                                                  : $signed(quo[15:0]);
                    end
                    dot_next   = '0;
                    den_e_next = '0;
                    qry_e_next = '0;
                    state_next = cssc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cssc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != cssc_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign score      = score_reg;
    assign zero_norm  = zero_norm_reg;
    assign last_score = last_score_reg;

    `include "cosine_similarity_score_assert.svh"

    `CSS_ASSERT_IMP(a_root_nonzero, root_start, (den_e_reg != '0) && (qry_e_reg != '0), "root started on zero energy")
    `CSS_ASSERT_IMP(a_units_free, root_start || div_start, !root_stat.busy && !div_stat.busy, "shared unit started while busy")
    `CSS_ASSERT_IMP(a_root_range, root_stat.done, root[15], "normalized root below 2^15")
    `CSS_ASSERT_NXT(a_acc_clear, (state_reg == cssc_pkg::ST_FIN) && fin_go, (dot_reg == '0) && (den_e_reg == '0) && (qry_e_reg == '0), "accumulators not cleared after score")
    `CSS_ASSERT_IMP(a_zero_score, out_valid_reg && zero_norm_reg, score_reg == 16'sd0, "zero energy with nonzero score")

endmodule

FILE: rtl/cssc_mul.sv
// Shared registered 17x17 signed multiplier.
// Depends on cssc_pkg for operand widths.
module cssc_mul (
    input  logic                                 clk,
    input  logic signed [cssc_pkg::SMP_W-1:0]    op_a,
    input  logic signed [cssc_pkg::SMP_W-1:0]    op_b,
    output logic signed [cssc_pkg::PROD_W-1:0]   prod
);

    logic signed [cssc_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/cssc_root.sv
// Iterative normalize-and-square-root unit: one 2-bit shift or one root
// step per cycle. Depends on cssc_pkg for widths, state enum and status struct.
module cssc_root (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cssc_pkg::EN_W-1:0]     energy,
    output logic [15:0]                   root,
    output logic signed [5:0]             k,
    output cssc_pkg::cssc_unit_stat_t     stat
);

    cssc_pkg::cssc_root_state_t st_reg, st_next;
    logic                       done_reg, done_next;
    logic [cssc_pkg::EN_W-1:0]  e_reg, e_next;
    logic signed [5:0]          k_reg, k_next;
    logic [31:0]                v_reg, v_next;
    logic [31:0]                res_reg, res_next;
    logic [30:0]                bit_reg, bit_next;
    logic [32:0]                trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= cssc_pkg::R_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg   <= e_next;
        k_reg   <= k_next;
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    always_comb
    begin
        st_next   = st_reg;
        done_next = 1'b0;
        e_next    = e_reg;
        k_next    = k_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        trial     = {1'b0, res_reg} + {2'b00, bit_reg};
        unique case (st_reg)
            cssc_pkg::R_IDLE:
            begin
                if (start)
                begin
                    e_next  = energy;
                    k_next  = 6'sd0;
                    st_next = cssc_pkg::R_NORM;
                end
            end
            cssc_pkg::R_NORM:
            begin
                // bring energy into [2^30, 2^32) by even shifts
                if (e_reg[cssc_pkg::EN_W-1:32] != '0)
                begin
                    e_next = e_reg >> 2;
                    k_next = k_reg - 6'sd1;
                end
                else if (e_reg[31:30] == 2'b00)
                begin
                    e_next = e_reg << 2;
                    k_next = k_reg + 6'sd1;
                end
                else
                begin
                    v_next   = e_reg[31:0];
                    res_next = 32'd0;
                    bit_next = 31'h4000_0000;
                    st_next  = cssc_pkg::R_ITER;
                end
            end
            cssc_pkg::R_ITER:
            begin
                if ({1'b0, v_reg} >= trial)
                begin
                    v_next   = v_reg - trial[31:0];
                    res_next = (res_reg >> 1) + {1'b0, bit_reg};
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    done_next = 1'b1;
                    st_next   = cssc_pkg::R_IDLE;
                end
            end
            default:
            begin
                st_next = cssc_pkg::R_IDLE;
            end
        endcase
    end

    assign root      = res_reg[15:0];
    assign k         = k_reg;
    assign stat.busy = (st_reg != cssc_pkg::R_IDLE);
    assign stat.done = done_reg;

endmodule

FILE: rtl/cssc_div.sv
// Restoring divider, one quotient bit per cycle, 17 bits with overflow flag.
// Depends on cssc_pkg for the state enum and status struct.
module cssc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [62:0]                 num,
    input  logic [31:0]                 den,
    output logic [16:0]                 quo,
    output logic                        sat,
    output cssc_pkg::cssc_unit_stat_t   stat
);

    cssc_pkg::cssc_div_state_t st_reg, st_next;
    logic        done_reg, done_next;
    logic [48:0] rem_reg, rem_next;
    logic [48:0] dvs_reg, dvs_next;
    logic [16:0] quo_reg, quo_next;
    logic        pre_sat_reg, pre_sat_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [63:0] n_round;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= cssc_pkg::D_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        quo_reg     <= quo_next;
        pre_sat_reg <= pre_sat_next;
        cnt_reg     <= cnt_next;
    end

    always_comb
    begin
        st_next      = st_reg;
        done_next    = 1'b0;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        quo_next     = quo_reg;
        pre_sat_next = pre_sat_reg;
        cnt_next     = cnt_reg;
        // numerator plus half the divisor gives round-half-up
        n_round      = {1'b0, num} + {33'd0, den[31:1]};
        ge           = (rem_reg >= dvs_reg);
        unique case (st_reg)
            cssc_pkg::D_IDLE:
            begin
                if (start)
                begin
                    pre_sat_next = |n_round[63:49];
                    rem_next     = n_round[48:0];
                    dvs_next     = {1'b0, den, 16'd0};
                    quo_next     = 17'd0;
                    cnt_next     = 5'd0;
                    st_next      = cssc_pkg::D_RUN;
                end
            end
            cssc_pkg::D_RUN:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dvs_reg;
                end
                quo_next = {quo_reg[15:0], ge};
                dvs_next = dvs_reg >> 1;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd16)
                begin
                    done_next = 1'b1;
                    st_next   = cssc_pkg::D_IDLE;
                end
            end
            default:
            begin
                st_next = cssc_pkg::D_IDLE;
            end
        endcase
    end

    assign quo       = quo_reg;
    // quotient of 2^16 or more is out of range either way
    assign sat       = pre_sat_reg | quo_reg[16];
    assign stat.busy = (st_reg != cssc_pkg::D_IDLE);
    assign stat.done = done_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for cosine_similarity_score.
// Runs directed and random vectors against a built-in score predictor.
// Depends on cssc_pkg (accumulator widths) and the RTL top level.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD = 10;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int LONG_HOLD  = 600;
    localparam int RAND_ITEMS = 600;
    localparam int TAIL_WAIT  = 200;

    localparam longint DOT_HI = (longint'(1) <<< (cssc_pkg::DOT_W - 1)) - 1;
    localparam longint DOT_LO = -DOT_HI - 1;
    localparam logic [63:0] NRG_HI = (64'd1 << cssc_pkg::EN_W) - 1;

    typedef struct packed {
        logic signed [15:0] data;
        logic signed [15:0] query;
        logic               last_el;
        logic               last_vec;
    } elem_beat_t;

    typedef struct packed {
        logic signed [15:0] score;
        logic               zero_norm;
        logic               last_score;
    } score_beat_t;

    typedef enum int {
        VK_FULL,
        VK_PARALLEL,
        VK_ANTI,
        VK_SMALL,
        VK_EXTREME,
        VK_DATA_ZERO,
        VK_QUERY_ZERO
    } vec_kind_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [15:0] data_element = '0;
    logic signed [15:0] query_element = '0;
    logic               last_element = 1'b0;
    logic               last_vector = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] score;
    logic               zero_norm;
    logic               last_score;

    elem_beat_t  element_queue[$];
    score_beat_t pending_scores[$];

    // predictor state
    longint      dot_acc = 0;
    logic [63:0] data_nrg = '0;
    logic [63:0] query_nrg = '0;

    logic in_fire = 1'b0;
    logic calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_ticket = 0;
    int   hold_seen = 0;
    int   elem_count = 0;
    int   mismatches = 0;

    cosine_similarity_score uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_element  (data_element),
        .query_element (query_element),
        .last_element  (last_element),
        .last_vector   (last_vector),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .score         (score),
        .zero_norm     (zero_norm),
        .last_score    (last_score)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Score predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        res = '0;
        bit_v = 64'd1 << 30;
        while (bit_v > v)
            bit_v >>= 2;
        while (bit_v != 0)
        begin
            if (v >= res + bit_v)
            begin
                v -= res + bit_v;
                res = (res >> 1) + bit_v;
            end
            else
                res >>= 1;
            bit_v >>= 2;
        end
        return res;
    endfunction

    // Root of e, normalized into [2^15, 2^16); k is the power-of-two scale.
    function automatic logic [63:0] energy_root(input logic [63:0] e, output int k);
        int s;
        s = 0;
        while (e >= 64'h1_0000_0000)
        begin
            e >>= 2;
            s--;
        end
        while (e < 64'h4000_0000)
        begin
            e <<= 2;
            s++;
        end
        k = s;
        return int_sqrt(e);
    endfunction

    function automatic logic signed [15:0] cosine_q15(input longint dot,
                                                      input logic [63:0] ed,
                                                      input logic [63:0] eq);
        int          kd, kq, sh;
        logic [63:0] rd, rq, den, mag, quo, neg_quo;
        logic        neg;
        rd = energy_root(ed, kd);
        rq = energy_root(eq, kq);
        den = rd * rq;
        neg = dot < 0;
        mag = neg ? 64'(-dot) : 64'(dot);
        sh = 15 + kd + kq;
        if (sh < 0)
            sh = 0;
        // numerator would not fit: force saturation by sign
        if (sh > 62 || mag > (64'h7FFF_FFFF_FFFF_FFFF >> sh))
            quo = 64'd40000;
        else
            quo = ((mag << sh) + (den >> 1)) / den;
        if (neg)
        begin
            neg_quo = -quo;
            return (quo > 64'd32768) ? 16'sh8000 : neg_quo[15:0];
        end
        return (quo > 64'd32767) ? 16'sh7FFF : quo[15:0];
    endfunction

    function automatic logic [63:0] nrg_add(input logic [63:0] acc,
                                            input logic signed [15:0] x);
        logic [63:0] s;
        s = acc + 64'(longint'(x) * longint'(x));
        return (s > NRG_HI) ? NRG_HI : s;
    endfunction

    task automatic fold_element(input elem_beat_t e);
        longint      s;
        score_beat_t r;
        s = dot_acc + longint'(e.data) * longint'(e.query);
        if (s > DOT_HI)
            s = DOT_HI;
        if (s < DOT_LO)
            s = DOT_LO;
        dot_acc = s;
        data_nrg = nrg_add(data_nrg, e.data);
        query_nrg = nrg_add(query_nrg, e.query);
        if (e.last_el)
        begin
            r.zero_norm = (data_nrg == 0) || (query_nrg == 0);
            r.score = r.zero_norm ? 16'sd0 : cosine_q15(dot_acc, data_nrg, query_nrg);
            r.last_score = e.last_vec;
            pending_scores.push_back(r);
            dot_acc = 0;
            data_nrg = '0;
            query_nrg = '0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int idle_len(input int pct_zero);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_zero)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic queue_elem(input logic signed [15:0] dv, input logic signed [15:0] qv,
                              input logic le, input logic lv);
        element_queue.push_back('{dv, qv, le, lv});
        elem_count++;
    endtask

    function automatic logic signed [15:0] rand_sample(input vec_kind_t kind);
        if (kind == VK_SMALL)
            return 16'($urandom_range(0, 8) - 4);
        if (kind == VK_EXTREME)
        begin
            case ($urandom_range(0, 4))
                0: return 16'sh8000;
                1: return 16'sh7FFF;
                2: return -16'sd1;
                3: return 16'sd0;
                default: return 16'sd1;
            endcase
        end
        return 16'($urandom);
    endfunction

    task automatic push_rand_vector(input int len);
        vec_kind_t          kind;
        int                 sel, i;
        logic signed [15:0] dv, qv;
        logic               lv;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            kind = VK_FULL;
        else if (sel < 48)
            kind = VK_PARALLEL;
        else if (sel < 55)
            kind = VK_ANTI;
        else if (sel < 70)
            kind = VK_SMALL;
        else if (sel < 85)
            kind = VK_EXTREME;
        else if (sel < 92)
            kind = VK_DATA_ZERO;
        else
            kind = VK_QUERY_ZERO;
        for (i = 0; i < len; i++)
        begin
            dv = (kind == VK_DATA_ZERO) ? 16'sd0 : rand_sample(kind);
            case (kind)
                VK_PARALLEL:   qv = dv >>> $urandom_range(0, 3);
                VK_ANTI:       qv = -dv;
                VK_QUERY_ZERO: qv = 16'sd0;
                default:       qv = rand_sample(kind);
            endcase
            // last_vector on an inner element must be ignored by the block
            if (i == len - 1)
                lv = ($urandom_range(0, 3) == 0);
            else
                lv = ($urandom_range(0, 7) == 0);
            queue_elem(dv, qv, i == len - 1, lv);
        end
    endtask

    task automatic drain_all();
        while (element_queue.size() != 0 || in_valid || pending_scores.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        elem_beat_t e;
        if (rst_n)
        begin
            if (!in_valid || in_fire)
            begin
                if (gap_left > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left--;
                end
                else if (element_queue.size() != 0)
                begin
                    e = element_queue.pop_front();
                    data_element <= e.data;
                    query_element <= e.query;
                    last_element <= e.last_el;
                    last_vector <= e.last_vec;
                    in_valid <= 1'b1;
                    gap_left = calm ? 0 : idle_len(50);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall generator
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int n;
        if (rst_n)
        begin
            if (hold_seen != hold_ticket)
            begin
                hold_seen = hold_ticket;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                n = idle_len(80);
                out_stall <= (n != 0);
                stall_left = (n > 0) ? n - 1 : 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input beat capture and output checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        score_beat_t got, want;
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (in_valid && !in_stall)
                fold_element('{data_element, query_element, last_element, last_vector});
            if (out_valid && !out_stall)
            begin
                got = '{score, zero_norm, last_score};
                if (pending_scores.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: unexpected score beat: score=%0d zero_norm=%0b last_score=%0b",
                                 $realtime, got.score, got.zero_norm, got.last_score);
                    mismatches++;
                end
                else
                begin
                    want = pending_scores.pop_front();
                    if (got.score !== want.score || got.zero_norm !== want.zero_norm ||
                        got.last_score !== want.last_score)
                    begin
                        if (mismatches < 10)
                            $display("%0t: score beat mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, want.score, want.zero_norm, want.last_score,
                                     got.score, got.zero_norm, got.last_score);
                        mismatches++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int  i, base, len, r;
        logic hold_done, pause_done;
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, zero energy, sign handling, ignored last_vector
        queue_elem(16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        queue_elem(16'sh8000, 16'sh8000, 1'b1, 1'b0);
        queue_elem(16'sh8000, 16'sh7FFF, 1'b1, 1'b1);
        queue_elem(16'sd0, 16'sd5, 1'b1, 1'b0);
        queue_elem(16'sd7, 16'sd0, 1'b1, 1'b0);
        queue_elem(16'sd0, 16'sd0, 1'b1, 1'b1);
        queue_elem(16'sd1, -16'sd1, 1'b0, 1'b0);
        queue_elem(-16'sd1, 16'sd1, 1'b0, 1'b0);
        queue_elem(16'sd2, -16'sd2, 1'b1, 1'b0);
        queue_elem(16'sd1, 16'sd0, 1'b0, 1'b0);
        queue_elem(16'sd0, 16'sd1, 1'b1, 1'b0);
        queue_elem(16'sd100, 16'sd200, 1'b0, 1'b1);
        queue_elem(16'sd300, -16'sd50, 1'b0, 1'b1);
        queue_elem(16'sh8000, 16'sh7FFF, 1'b1, 1'b0);
        queue_elem(16'sd1, 16'sd1, 1'b1, 1'b0);
        queue_elem(-16'sd1, 16'sd1, 1'b1, 1'b1);
        queue_elem(16'sh7FFF, 16'sh8000, 1'b0, 1'b0);
        queue_elem(-16'sd1, 16'sd1, 1'b0, 1'b0);
        queue_elem(16'sd0, 16'sh7FFF, 1'b0, 1'b0);
        queue_elem(16'sh8000, -16'sd1, 1'b1, 1'b1);
        drain_all();

        base = elem_count;
        while (elem_count - base < RAND_ITEMS)
        begin
            while (element_queue.size() > 4)
                @(posedge clk);
            if (!hold_done && elem_count - base >= 200)
            begin
                // receiver holds off while short vectors keep coming
                hold_done = 1'b1;
                hold_ticket++;
                repeat (8) push_rand_vector($urandom_range(1, 3));
            end
            if (!pause_done && elem_count - base >= 400)
            begin
                pause_done = 1'b1;
                drain_all();
            end
            calm = (elem_count - base >= 300) && (elem_count - base < 360);
            r = $urandom_range(0, 99);
            if (r < 80)
                len = $urandom_range(1, 8);
            else if (r < 95)
                len = $urandom_range(9, 32);
            else
                len = $urandom_range(33, 64);
            push_rand_vector(len);
        end
        calm = 1'b0;

        drain_all();
        repeat (TAIL_WAIT) @(posedge clk);
        if (pending_scores.size() != 0)
            mismatches += pending_scores.size();
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
